/* design/two_line_scroll_marquee_defines.svh */
// Assertion macros for the two-line scroll marquee.
`ifndef TWO_LINE_SCROLL_MARQUEE_DEFINES_SVH
`define TWO_LINE_SCROLL_MARQUEE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define TLSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("two_line_scroll_marquee: assertion failed");

// Next-cycle implication, checked on clk and disabled during reset.
`define TLSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("two_line_scroll_marquee: assertion failed");

`endif

/* design/tlsm_pkg.sv */
// Types, constants and the sequencer program of the two-line scroll marquee.
package tlsm_pkg;

  localparam int WINDOW_CHARS = 16;
  localparam int WIN_W        = $clog2(WINDOW_CHARS);
  localparam int CHAR_W       = 8;
  localparam int POS_W        = 8;
  localparam int LEN_W        = 9;
  localparam int OFF_W        = 10;
  localparam int CELL_W       = WIN_W + 1;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_SET_LEN = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              line_sel;
    logic [POS_W-1:0]  char_pos;
    logic [CHAR_W-1:0] char_code;
    logic [LEN_W-1:0]  text_length;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic [CELL_W-1:0] cell_index;
    logic              frame_last;
  } out_word_t;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_BASE0,
    STEP_EMIT0,
    STEP_BASE1,
    STEP_EMIT1,
    STEP_FIN
  } step_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_START,
    COND_LAST
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  ld_base;
    logic  emit;
    logic  line;
    logic  advance;
    cond_t cond;
    step_t jmp;
  } ucw_t;

  typedef struct packed {
    logic             in_ready;
    logic             ld_base;
    logic             issue;
    logic             line;
    logic             advance;
    logic [WIN_W-1:0] cnt;
  } seq_ctl_t;

  function automatic ucw_t ucode(step_t step);
    ucw_t w;
    unique case (step)
      STEP_IDLE:  w = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, COND_START,  STEP_BASE0};
      STEP_BASE0: w = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_EMIT0};
      STEP_EMIT0: w = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_LAST,   STEP_BASE1};
      STEP_BASE1: w = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, COND_ALWAYS, STEP_EMIT1};
      STEP_EMIT1: w = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, COND_LAST,   STEP_FIN};
      STEP_FIN:   w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, COND_ALWAYS, STEP_IDLE};
      default:    w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* design/tlsm_line_ram.sv */
// Line store memory with one write port and one registered read port.
module tlsm_line_ram import tlsm_pkg::*; #(
  parameter int AW = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [2**AW];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/tlsm_useq.sv */
// Microcoded sequencer: step counter, cell counter and program lookup.
module tlsm_useq import tlsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  cmd_t     in_cmd,
  input  logic     issue_ok,
  output seq_ctl_t ctl
);

  step_t            step_r, step_nxt;
  logic [WIN_W-1:0] cnt_r, cnt_nxt;
  ucw_t             uw;
  logic             issue;
  logic             start;
  logic             last;
  logic             taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      cnt_r  <= '0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_comb begin
    uw    = ucode(step_r);
    issue = uw.emit && issue_ok;
    start = in_valid && uw.in_ready && (in_cmd == CMD_SET_LEN || in_cmd == CMD_TICK);
    last  = issue && (cnt_r == WIN_W'(WINDOW_CHARS - 1));
    unique case (uw.cond)
      COND_ALWAYS: taken = 1'b1;
      COND_START:  taken = start;
      COND_LAST:   taken = last;
      default:     taken = 1'b0;
    endcase
    step_nxt = taken ? uw.jmp : step_r;
    priority if (uw.ld_base) begin
      cnt_nxt = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r + WIN_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
    ctl.in_ready = uw.in_ready;
    ctl.ld_base  = uw.ld_base;
    ctl.issue    = issue;
    ctl.line     = uw.line;
    ctl.advance  = uw.advance;
    ctl.cnt      = cnt_r;
  end

endmodule

/* design/tlsm_datapath.sv */
// Datapath: line lengths, scroll offsets, window base, line store and output stage.
module tlsm_datapath import tlsm_pkg::*; #(
  parameter int LINE_CHARS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_word_t  in_data,
  input  seq_ctl_t  ctl,
  output logic      issue_ok,
  output logic      out_valid,
  output out_word_t out_data,
  input  logic      out_stall
);

  localparam int ADDR_W = $clog2(LINE_CHARS);
  localparam int MEM_AW = ADDR_W + 1;

  logic        [LEN_W-1:0]  len_r [2];
  logic        [LEN_W-1:0]  len_nxt [2];
  logic signed [OFF_W-1:0]  off_r [2];
  logic signed [OFF_W-1:0]  off_nxt [2];
  logic                     tick_r, tick_nxt;
  logic        [LEN_W-1:0]  base_r, base_nxt;
  logic                     pend_r, pend_nxt;
  logic                     pend_space_r;
  logic        [CELL_W-1:0] pend_cell_r;
  logic                     pend_last_r;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_data_r;

  logic                     accept;
  logic                     start;
  logic        [LEN_W-1:0]  len_sat;
  logic                     wr_en;
  logic        [MEM_AW-1:0] wr_addr;
  logic        [LEN_W-1:0]  sel_len;
  logic signed [OFF_W-1:0]  sel_off;
  logic        [LEN_W-1:0]  sel_pad;
  logic signed [OFF_W:0]    off_win;
  logic signed [OFF_W:0]    pad_s;
  logic        [LEN_W-1:0]  pos;
  logic                     space;
  logic        [MEM_AW-1:0] rd_addr;
  logic        [CHAR_W-1:0] ram_q;
  logic                     move;
  logic        [LEN_W-1:0]  adv_pad [2];
  logic signed [OFF_W:0]    adv_off [2];

  tlsm_line_ram #(.AW(MEM_AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.char_code),
    .rd_en   (ctl.issue),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    accept  = in_valid && ctl.in_ready;
    start   = accept && (in_data.cmd == CMD_SET_LEN || in_data.cmd == CMD_TICK);
    len_sat = (32'(in_data.text_length) > LINE_CHARS) ? LEN_W'(LINE_CHARS)
                                                      : in_data.text_length;
    wr_en   = accept && (in_data.cmd == CMD_WRITE) && (32'(in_data.char_pos) < LINE_CHARS);
    wr_addr = {in_data.line_sel, ADDR_W'(in_data.char_pos)};

    sel_len = len_r[ctl.line];
    sel_off = off_r[ctl.line];
    sel_pad = (sel_len < LEN_W'(WINDOW_CHARS)) ? LEN_W'(WINDOW_CHARS) : sel_len;
    off_win = {sel_off[OFF_W-1], sel_off} + (OFF_W+1)'(WINDOW_CHARS);
    pad_s   = $signed({2'b00, sel_pad});
    priority if (sel_off < 0) begin
      base_nxt = '0;
    end else if (off_win > pad_s) begin
      base_nxt = sel_pad - LEN_W'(WINDOW_CHARS);
    end else begin
      base_nxt = sel_off[LEN_W-1:0];
    end

    pos     = base_r + LEN_W'(ctl.cnt);
    space   = !(pos < sel_len);
    rd_addr = {ctl.line, ADDR_W'(pos)};

    move     = pend_r && (!out_valid_r || !out_stall);
    issue_ok = !pend_r || move;
    pend_nxt = ctl.issue ? 1'b1 : (move ? 1'b0 : pend_r);
    priority if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    tick_nxt = start ? (in_data.cmd == CMD_TICK) : tick_r;

    for (int k = 0; k < 2; k++) begin
      adv_pad[k] = (len_r[k] < LEN_W'(WINDOW_CHARS)) ? LEN_W'(WINDOW_CHARS) : len_r[k];
      adv_off[k] = {off_r[k][OFF_W-1], off_r[k]} + (OFF_W+1)'(WINDOW_CHARS);
      len_nxt[k] = len_r[k];
      off_nxt[k] = off_r[k];
      if (accept && in_data.cmd == CMD_SET_LEN && in_data.line_sel == 1'(k)) begin
        len_nxt[k] = len_sat;
        off_nxt[k] = -OFF_W'(1);
      end else if (ctl.advance && tick_r) begin
        if (adv_off[k] > $signed({2'b00, adv_pad[k]})) begin
          off_nxt[k] = -OFF_W'(1);
        end else begin
          off_nxt[k] = off_r[k] + OFF_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r[0]    <= '0;
      len_r[1]    <= '0;
      off_r[0]    <= '0;
      off_r[1]    <= '0;
      tick_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r[0]    <= len_nxt[0];
      len_r[1]    <= len_nxt[1];
      off_r[0]    <= off_nxt[0];
      off_r[1]    <= off_nxt[1];
      tick_r      <= tick_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_base) begin
      base_r <= base_nxt;
    end
    if (ctl.issue) begin
      pend_space_r <= space;
      pend_cell_r  <= {ctl.line, ctl.cnt};
      pend_last_r  <= ctl.line && (ctl.cnt == WIN_W'(WINDOW_CHARS - 1));
    end
    if (move) begin
      out_data_r.out_char   <= pend_space_r ? SPACE_CODE : ram_q;
      out_data_r.cell_index <= pend_cell_r;
      out_data_r.frame_last <= pend_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/two_line_scroll_marquee.sv */
// Top level of the two-line scroll marquee for a 16x2 character display.
//
// Input words carry a command: write a character into line store 0 or 1,
// set a line's length (which restarts its scroll and sends a frame), or
// tick (send a frame, then advance both scroll offsets).
// A frame is 32 output words, cells 0-15 for the first row and 16-31 for
// the second, with frame_last set on cell 31.
// A character write does not stall the input. A length or tick word stalls
// the input for one base step per row, one line store read per cell, and
// one step to advance the offsets. The single read port of the line store
// sets the rate of one cell per cycle while the output is not stalled.
// A cell goes from the line store's read register to the output register.
// A stalled output holds its word; reads then wait until the output stage
// frees up, so no cell is lost. A new input word is taken while the last
// cells of a frame are still draining.
// Reset clears both lengths and offsets; the line store is not cleared.
module two_line_scroll_marquee import tlsm_pkg::*; #(
  parameter int LINE_CHARS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  `include "two_line_scroll_marquee_defines.svh"

  seq_ctl_t ctl;
  logic     dp_issue_ok;

  tlsm_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .issue_ok (dp_issue_ok),
    .ctl      (ctl)
  );

  tlsm_datapath #(.LINE_CHARS(LINE_CHARS)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .ctl       (ctl),
    .issue_ok  (dp_issue_ok),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  assign in_stall = !ctl.in_ready;

  `TLSM_ASSERT_IMP(a_issue_room, ctl.issue, dp_issue_ok)
  `TLSM_ASSERT_IMP(a_last_cell, out_valid && out_data.frame_last, &out_data.cell_index)
  `TLSM_ASSERT_NXT(a_start_busy, in_valid && !in_stall && (in_data.cmd == CMD_TICK || in_data.cmd == CMD_SET_LEN), in_stall)

endmodule
